[rtl/mtg_pkg.sv]
// ---------------------------------------------------------------------------
// mtg_pkg
// shared types and constants of the goal-seeking point mover
// ---------------------------------------------------------------------------
package mtg_pkg;

    localparam int POS_WIDTH_DEF  = 32;
    localparam int QUAT_WIDTH_DEF = 16;

    localparam logic [30:0] STEP_LENGTH_RST      = 31'd3277;
    localparam logic [30:0] ARRIVE_THRESHOLD_RST = 31'd6554;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET_GOAL = 2'd1,
        OP_RESTART  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        REG_STEP_LENGTH      = 3'd0,
        REG_ARRIVE_THRESHOLD = 3'd1,
        REG_START_X          = 3'd2,
        REG_START_Y          = 3'd3,
        REG_START_Z          = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_NORM,
        ST_SQ,
        ST_THR,
        ST_DSQ,
        ST_STEP_MUL,
        ST_CDIV,
        ST_UPD,
        ST_RSQ,
        ST_HLOAD,
        ST_HDIV,
        ST_HSQ,
        ST_DONE
    } state_t;

endpackage

[rtl/move_toward_goal_step_top.sv]
// ---------------------------------------------------------------------------
// move_toward_goal_step_top
// point mover that steps a 3d position toward an armed goal, bit-serial
// ---------------------------------------------------------------------------
// Items enter on the s_ channel (valid/ready) with an operation code and a
// goal. set_goal and restart are taken while idle and give no result. A
// tick gives one pose on the m_ channel (valid/ready). Registers are written
// through cfg_wr_en/cfg_addr/cfg_wdata with no wait.
// One item is worked on at a time. A tick with no armed goal goes straight
// to the result step; an armed tick that does not move passes delta, range
// normalize and four shift-add squares. A moving tick then runs a square
// root, three rounds of a multiply and a restoring divide, a planar square
// root and two heading rounds of a divide and a root. The multiplier,
// divider and root unit are serial and shared. After reset the position is
// zero, no goal is armed and the heading is identity. The result sits in an
// output register; the next item is accepted while it waits, and a later
// tick holds in its final step until the receiver takes the earlier pose.
// ---------------------------------------------------------------------------
module move_toward_goal_step_top
    import mtg_pkg::*;
#(
    parameter int POS_WIDTH  = POS_WIDTH_DEF,
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_addr,
    input  logic [31:0]                  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic signed [31:0]           s_target_x,
    input  logic signed [31:0]           s_target_y,
    input  logic signed [31:0]           s_target_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [POS_WIDTH-1:0]  m_out_x,
    output logic signed [POS_WIDTH-1:0]  m_out_y,
    output logic signed [POS_WIDTH-1:0]  m_out_z,
    output logic signed [QUAT_WIDTH-1:0] m_quat_z,
    output logic signed [QUAT_WIDTH-1:0] m_quat_w,
    output logic                         m_moved,
    output logic                         m_saturated
);

    localparam int QF    = QUAT_WIDTH - 2;
    localparam int HK    = 2 * QF - 1;
    localparam int EW    = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 1;
    localparam int NPW   = EW + 2;
    localparam int CN    = 63;
    localparam int HN    = 33 + HK;
    localparam int DVD_W = (CN > HN) ? CN : HN;
    localparam int CNT_W = $clog2(DVD_W);

    localparam logic signed [QUAT_WIDTH-1:0] QONE = {2'b01, {QF{1'b0}}};
    localparam logic signed [NPW-1:0] PMAX =
        {{(NPW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [NPW-1:0] PMIN =
        {{(NPW-POS_WIDTH+1){1'b1}}, {(POS_WIDTH-1){1'b0}}};

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(30);
    localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(31);
    localparam logic [CNT_W-1:0] CDV_LAST = CNT_W'(CN - 1);
    localparam logic [CNT_W-1:0] HDV_LAST = CNT_W'(HN - 1);

    function automatic logic signed [POS_WIDTH-1:0] clamp_pos(
        input logic signed [NPW-1:0] v
    );
        logic signed [NPW-1:0] c;
        c = v;
        if (v > PMAX) begin
            c = PMAX;
        end else if (v < PMIN) begin
            c = PMIN;
        end
        return c[POS_WIDTH-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [30:0]                  step_reg, thr_reg;
    logic signed [31:0]           start_reg [3];
    logic signed [POS_WIDTH-1:0]  pos_reg [3];
    logic signed [31:0]           goal_reg [3];
    logic                         armed_reg;
    logic signed [QUAT_WIDTH-1:0] hz_reg, hw_reg;

    logic [EW-1:0]                mag_reg [3];
    logic                         neg_reg [3];
    logic                         far_reg;
    logic [1:0]                   idx_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         moved_reg, sat_reg;

    logic [63:0]                  acc_reg, sum_reg, planar_reg;
    logic [61:0]                  mul_a_reg;
    logic [30:0]                  mul_b_reg;
    logic [63:0]                  sq_n_reg;
    logic [32:0]                  sq_rem_reg;
    logic [31:0]                  sq_root_reg;
    logic [DVD_W-1:0]             div_dq_reg;
    logic [31:0]                  div_rem_reg;
    logic [31:0]                  dist_reg;

    logic                         m_valid_reg;
    logic signed [POS_WIDTH-1:0]  o_x_reg, o_y_reg, o_z_reg;
    logic signed [QUAT_WIDTH-1:0] o_qz_reg, o_qw_reg;
    logic                         o_moved_reg, o_sat_reg;

    logic        s_fire, hi_any, mul_last, sq_last, out_free;
    logic [63:0] mul_acc_next;
    logic [34:0] sq_t, sq_trial;
    logic        sq_ge;
    logic [32:0] sq_rem_next;
    logic [31:0] sq_root_next;
    logic [32:0] sq_round;
    logic [32:0] div_t;
    logic        div_ge;
    logic [31:0] div_rem_next;
    logic [DVD_W-1:0] div_dq_next;
    logic [30:0] ms [3];
    logic [32:0] h_plus, h_minus, h_sel;
    logic signed [NPW-1:0] np;
    logic signed [POS_WIDTH-1:0] np_c;
    logic [62:0] c_num;

    // serial arithmetic steps
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ms[i] = mag_reg[i][30:0];
        end
        hi_any       = (|mag_reg[0][EW-1:31]) | (|mag_reg[1][EW-1:31])
                     | (|mag_reg[2][EW-1:31]);
        mul_acc_next = acc_reg + (mul_b_reg[0] ? {2'b00, mul_a_reg} : 64'd0);
        sq_t         = {sq_rem_reg, sq_n_reg[63:62]};
        sq_trial     = {1'b0, sq_root_reg, 2'b01};
        sq_ge        = sq_t >= sq_trial;
        sq_rem_next  = sq_ge ? 33'(sq_t - sq_trial) : sq_t[32:0];
        sq_root_next = {sq_root_reg[30:0], sq_ge};
        sq_round     = {1'b0, sq_root_next}
                     + {32'd0, (sq_rem_next > {1'b0, sq_root_next})};
        div_t        = {div_rem_reg, div_dq_reg[DVD_W-1]};
        div_ge       = div_t >= {1'b0, dist_reg};
        div_rem_next = div_ge ? 32'(div_t - {1'b0, dist_reg}) : div_t[31:0];
        div_dq_next  = {div_dq_reg[DVD_W-2:0], div_ge};
        h_plus       = neg_reg[0] ? {1'b0, dist_reg} - {2'b00, ms[0]}
                                  : {1'b0, dist_reg} + {2'b00, ms[0]};
        h_minus      = neg_reg[0] ? {1'b0, dist_reg} + {2'b00, ms[0]}
                                  : {1'b0, dist_reg} - {2'b00, ms[0]};
        h_sel        = (idx_reg == 2'd0) ? h_plus : h_minus;
        c_num        = mul_acc_next[62:0] + {32'd0, dist_reg[31:1]};
        if (neg_reg[idx_reg]) begin
            np = NPW'(pos_reg[idx_reg]) - NPW'({1'b0, div_dq_reg[32:0]});
        end else begin
            np = NPW'(pos_reg[idx_reg]) + NPW'({1'b0, div_dq_reg[32:0]});
        end
        np_c         = clamp_pos(np);
        mul_last     = cnt_reg == MUL_LAST;
        sq_last      = cnt_reg == SQ_LAST;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && op_t'(s_operation) == OP_TICK) begin
                    state_next = armed_reg ? ST_DELTA : ST_DONE;
                end
            end
            ST_DELTA: state_next = ST_NORM;
            ST_NORM: begin
                if (!hi_any) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (mul_last && idx_reg == 2'd2) begin
                    state_next = ST_THR;
                end
            end
            ST_THR: begin
                if (mul_last) begin
                    state_next = (far_reg || sum_reg > mul_acc_next) ? ST_DSQ : ST_DONE;
                end
            end
            ST_DSQ: begin
                if (sq_last) begin
                    state_next = ST_STEP_MUL;
                end
            end
            ST_STEP_MUL: begin
                if (mul_last) begin
                    state_next = ST_CDIV;
                end
            end
            ST_CDIV: begin
                if (cnt_reg == CDV_LAST) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: state_next = (idx_reg == 2'd2) ? ST_RSQ : ST_STEP_MUL;
            ST_RSQ: begin
                if (sq_last) begin
                    state_next = (sq_root_next == 32'd0) ? ST_DONE : ST_HLOAD;
                end
            end
            ST_HLOAD: state_next = ST_HDIV;
            ST_HDIV: begin
                if (cnt_reg == HDV_LAST) begin
                    state_next = ST_HSQ;
                end
            end
            ST_HSQ: begin
                if (sq_last) begin
                    state_next = (idx_reg == 2'd0) ? ST_HLOAD : ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready     = state_reg == ST_IDLE;
        s_fire      = s_valid && s_ready;
        out_free    = !m_valid_reg || m_ready;
        m_valid     = m_valid_reg;
        m_out_x     = o_x_reg;
        m_out_y     = o_y_reg;
        m_out_z     = o_z_reg;
        m_quat_z    = o_qz_reg;
        m_quat_w    = o_qw_reg;
        m_moved     = o_moved_reg;
        m_saturated = o_sat_reg;
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            armed_reg   <= 1'b0;
            step_reg    <= STEP_LENGTH_RST;
            thr_reg     <= ARRIVE_THRESHOLD_RST;
            for (int i = 0; i < 3; i++) begin
                start_reg[i] <= '0;
                pos_reg[i]   <= '0;
            end
            hz_reg      <= '0;
            hw_reg      <= QONE;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_addr))
                    REG_STEP_LENGTH:      step_reg     <= cfg_wdata[30:0];
                    REG_ARRIVE_THRESHOLD: thr_reg      <= cfg_wdata[30:0];
                    REG_START_X:          start_reg[0] <= cfg_wdata;
                    REG_START_Y:          start_reg[1] <= cfg_wdata;
                    REG_START_Z:          start_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (op_t'(s_operation))
                            OP_SET_GOAL: armed_reg <= 1'b1;
                            OP_RESTART: begin
                                armed_reg <= 1'b0;
                                hz_reg    <= '0;
                                hw_reg    <= QONE;
                                for (int i = 0; i < 3; i++) begin
                                    pos_reg[i] <= clamp_pos(NPW'(start_reg[i]));
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_UPD: pos_reg[idx_reg] <= np_c;
                ST_RSQ: begin
                    if (sq_last && sq_root_next == 32'd0) begin
                        hz_reg <= '0;
                        hw_reg <= QONE;
                    end
                end
                ST_HSQ: begin
                    if (sq_last) begin
                        if (idx_reg == 2'd0) begin
                            hw_reg <= QUAT_WIDTH'(sq_round);
                        end else if (neg_reg[1] && ms[1] != 31'd0) begin
                            hz_reg <= -QUAT_WIDTH'(sq_round);
                        end else begin
                            hz_reg <= QUAT_WIDTH'(sq_round);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // serial datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                moved_reg <= 1'b0;
                sat_reg   <= 1'b0;
                far_reg   <= 1'b0;
                if (s_fire && op_t'(s_operation) == OP_SET_GOAL) begin
                    goal_reg[0] <= s_target_x;
                    goal_reg[1] <= s_target_y;
                    goal_reg[2] <= s_target_z;
                end
            end
            ST_DELTA: begin
                for (int i = 0; i < 3; i++) begin
                    logic signed [EW-1:0] d;
                    d = EW'(goal_reg[i]) - EW'(pos_reg[i]);
                    neg_reg[i] <= d[EW-1];
                    mag_reg[i] <= d[EW-1] ? -d : d;
                end
            end
            ST_NORM: begin
                if (hi_any) begin
                    far_reg <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end else begin
                    acc_reg   <= '0;
                    mul_a_reg <= {31'd0, ms[0]};
                    mul_b_reg <= ms[0];
                    cnt_reg   <= '0;
                    idx_reg   <= 2'd0;
                end
            end
            ST_SQ: begin
                if (mul_last) begin
                    cnt_reg <= '0;
                    if (idx_reg == 2'd2) begin
                        sum_reg   <= mul_acc_next;
                        acc_reg   <= '0;
                        mul_a_reg <= {31'd0, thr_reg};
                        mul_b_reg <= thr_reg;
                    end else begin
                        if (idx_reg == 2'd1) begin
                            planar_reg <= mul_acc_next;
                        end
                        acc_reg   <= mul_acc_next;
                        idx_reg   <= idx_reg + 1'b1;
                        mul_a_reg <= {31'd0, ms[idx_reg + 1'b1]};
                        mul_b_reg <= ms[idx_reg + 1'b1];
                    end
                end else begin
                    acc_reg   <= mul_acc_next;
                    mul_a_reg <= mul_a_reg << 1;
                    mul_b_reg <= mul_b_reg >> 1;
                    cnt_reg   <= cnt_reg + 1'b1;
                end
            end
            ST_THR: begin
                acc_reg   <= mul_acc_next;
                mul_a_reg <= mul_a_reg << 1;
                mul_b_reg <= mul_b_reg >> 1;
                cnt_reg   <= mul_last ? '0 : cnt_reg + 1'b1;
                sq_n_reg    <= sum_reg;
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            ST_DSQ, ST_RSQ, ST_HSQ: begin
                sq_n_reg    <= sq_n_reg << 2;
                sq_rem_reg  <= sq_rem_next;
                sq_root_reg <= sq_root_next;
                cnt_reg     <= sq_last ? '0 : cnt_reg + 1'b1;
                if (sq_last && state_reg == ST_DSQ) begin
                    dist_reg  <= sq_root_next;
                    idx_reg   <= 2'd0;
                    acc_reg   <= '0;
                    mul_a_reg <= {31'd0, step_reg};
                    mul_b_reg <= ms[0];
                end
                if (sq_last && state_reg == ST_RSQ) begin
                    dist_reg <= sq_root_next;
                    idx_reg  <= 2'd0;
                end
                if (sq_last && state_reg == ST_HSQ) begin
                    idx_reg <= 2'd1;
                end
            end
            ST_STEP_MUL: begin
                acc_reg   <= mul_acc_next;
                mul_a_reg <= mul_a_reg << 1;
                mul_b_reg <= mul_b_reg >> 1;
                cnt_reg   <= mul_last ? '0 : cnt_reg + 1'b1;
                div_dq_reg  <= DVD_W'(c_num) << (DVD_W - CN);
                div_rem_reg <= '0;
            end
            ST_CDIV, ST_HDIV: begin
                div_dq_reg  <= div_dq_next;
                div_rem_reg <= div_rem_next;
                sq_n_reg    <= 64'(div_dq_next);
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                if ((state_reg == ST_CDIV && cnt_reg == CDV_LAST)
                    || (state_reg == ST_HDIV && cnt_reg == HDV_LAST)) begin
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            ST_UPD: begin
                if (np_c != pos_reg[idx_reg]) begin
                    moved_reg <= 1'b1;
                end
                if (np != NPW'(np_c)) begin
                    sat_reg <= 1'b1;
                end
                idx_reg   <= idx_reg + 1'b1;
                acc_reg   <= '0;
                mul_a_reg <= {31'd0, step_reg};
                mul_b_reg <= ms[idx_reg + 1'b1];
                cnt_reg   <= '0;
                sq_n_reg    <= planar_reg;
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            ST_HLOAD: begin
                div_dq_reg  <= DVD_W'(h_sel) << (DVD_W - 33);
                div_rem_reg <= '0;
                cnt_reg     <= '0;
            end
            default: ;
        endcase
        if (state_reg == ST_DONE && out_free) begin
            o_x_reg     <= pos_reg[0];
            o_y_reg     <= pos_reg[1];
            o_z_reg     <= pos_reg[2];
            o_qz_reg    <= hz_reg;
            o_qw_reg    <= hw_reg;
            o_moved_reg <= moved_reg;
            o_sat_reg   <= sat_reg;
        end
    end

    a_goal_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_operation == OP_SET_GOAL) |=> armed_reg)
        else $error("set_goal transfer did not arm the goal");

    a_restart_heading: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_operation == OP_RESTART) |=> (!armed_reg && hw_reg == QONE
            && hz_reg == '0))
        else $error("restart did not reset heading and goal flag");

    a_quat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quat_w <= QONE && m_quat_w >= -QONE
            && m_quat_z <= QONE && m_quat_z >= -QONE))
        else $error("quaternion component out of range");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final step");

endmodule
